// ----- rtl/lnut_pkg.sv -----
package lnut_pkg;

  localparam int unsigned NAME_CHARS   = 6;
  localparam int unsigned LETTER_CHARS = 3;
  localparam int unsigned LATENCY      = 2 + NAME_CHARS + 2;

  localparam logic [5:0]  RADIX     = 6'd36;
  // floor(x / 9) = (x * DIV_MAGIC) >> DIV_SHIFT, exact for x < 2^30
  localparam logic [29:0] DIV_MAGIC = 30'd954437177;
  localparam int unsigned DIV_SHIFT = 33;

  localparam logic [7:0] ASCII_LA    = 8'h61;
  localparam logic [7:0] ASCII_LZ    = 8'h7a;
  localparam logic [7:0] ASCII_0     = 8'h30;
  localparam logic [7:0] ASCII_9     = 8'h39;
  localparam logic [7:0] LETTER_OFS  = 8'd87;   // 'a' - 10

  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_NAME_BASE = 2'd0;
  localparam logic [1:0] REG_ID_BASE   = 2'd1;
  localparam logic [1:0] REG_ID_LIMIT  = 2'd2;

  localparam logic [31:0] RST_NAME_BASE = 32'd621924480;
  localparam logic [31:0] RST_ID_BASE   = 32'd100000;
  localparam logic [31:0] RST_ID_LIMIT  = 32'd1554923197;

  typedef enum logic {
    OP_BY_NAME = 1'b0,
    OP_BY_ID   = 1'b1
  } op_e;

  typedef struct packed {
    logic [31:0] name_base;
    logic [31:0] id_base;
    logic [31:0] id_limit;
  } cfg_t;

  // one transaction in flight along the chain
  typedef struct packed {
    logic        vld;
    op_e         op;
    logic        fail;
    logic [31:0] acc;
    logic [47:0] text;
    logic [31:0] id;
  } stage_t;

endpackage

// ----- rtl/lnut_front.sv -----
module lnut_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              operation_i,
  input  logic [55:0]       name_bytes_i,
  input  logic [31:0]       id_value_i,
  input  lnut_pkg::cfg_t    cfg_i,
  output lnut_pkg::stage_t  stage_o
);
  import lnut_pkg::*;

  stage_t      a_d, a_q, b_d, b_q;
  logic [32:0] diff;
  logic [32:0] sum;

  // stage A: by-name terminator check and text load, by-id range check and id - id_base
  always_comb begin
    diff    = {1'b0, id_value_i} - {1'b0, cfg_i.id_base};
    a_d     = '0;
    a_d.vld = start;
    a_d.op  = op_e'(operation_i);
    a_d.id  = id_value_i;
    if (op_e'(operation_i) == OP_BY_NAME) begin
      a_d.fail = (name_bytes_i[7:0] != 8'd0);
      a_d.text = name_bytes_i[55:8];
    end else begin
      a_d.fail = diff[32] || (id_value_i > cfg_i.id_limit);
      a_d.acc  = diff[31:0];
    end
  end

  // stage B: by id, add the name base; anything past 32 bits cannot encode
  always_comb begin
    sum = {1'b0, a_q.acc} + {1'b0, cfg_i.name_base};
    b_d = a_q;
    if (a_q.op == OP_BY_ID) begin
      b_d.acc  = sum[31:0];
      b_d.fail = a_q.fail || sum[32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
    end else begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign stage_o = b_q;

endmodule

// ----- rtl/lnut_cell.sv -----
module lnut_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              dec_letter_i,
  input  lnut_pkg::stage_t  stage_i,
  output lnut_pkg::stage_t  stage_o
);
  import lnut_pkg::*;

  stage_t      st_d, st_q;
  logic [7:0]  ch;
  logic        dec_ok;
  logic [7:0]  dec_dig;
  logic [59:0] prod;
  logic [26:0] quo;
  logic [31:0] rem_full;
  logic [5:0]  rem;
  logic        enc_ok;
  logic [7:0]  enc_ch;

  always_comb begin
    // decode: leading character sits at the top of text
    ch = stage_i.text[47:40];
    if (dec_letter_i) begin
      dec_ok  = (ch >= ASCII_LA) && (ch <= ASCII_LZ);
      dec_dig = ch - LETTER_OFS;
    end else begin
      dec_ok  = (ch >= ASCII_0) && (ch <= ASCII_9);
      dec_dig = ch - ASCII_0;
    end

    // encode: acc / 36 as (acc >> 2) / 9 by reciprocal
    prod     = 60'(stage_i.acc[31:2]) * 60'(DIV_MAGIC);
    quo      = prod[59:DIV_SHIFT];
    rem_full = stage_i.acc - 32'(quo) * 32'(RADIX);
    rem      = rem_full[5:0];
    if (!dec_letter_i) begin
      enc_ok = (rem >= 6'd10);
      enc_ch = 8'(rem) + LETTER_OFS;
    end else begin
      enc_ok = (rem < 6'd10);
      enc_ch = 8'(rem) + ASCII_0;
    end

    st_d = stage_i;
    if (stage_i.op == OP_BY_NAME) begin
      st_d.fail = stage_i.fail || !dec_ok;
      st_d.acc  = stage_i.acc * 32'(RADIX) + 32'(dec_dig[5:0]);
      st_d.text = {stage_i.text[39:0], stage_i.text[47:40]};
    end else begin
      st_d.fail = stage_i.fail || !enc_ok;
      st_d.acc  = 32'(quo);
      st_d.text = {enc_ch, stage_i.text[47:8]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign stage_o = st_q;

endmodule

// ----- rtl/lnut_back.sv -----
module lnut_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lnut_pkg::stage_t  stage_i,
  input  lnut_pkg::cfg_t    cfg_i,
  output logic              done_o,
  output logic              status_o,
  output logic [31:0]       id_out_o,
  output logic [47:0]       name_out_o
);
  import lnut_pkg::*;

  stage_t      p_d, p_q;
  logic [32:0] diff;
  logic [32:0] uid;
  logic        fail;
  logic        done_q;
  logic        status_q;
  logic [31:0] id_q;
  logic [47:0] name_q;

  // name: value - name_base, borrow means not found
  // id: a nonzero quotient left after six digits means too long
  always_comb begin
    diff = {1'b0, stage_i.acc} - {1'b0, cfg_i.name_base};
    p_d  = stage_i;
    if (stage_i.op == OP_BY_NAME) begin
      p_d.fail = stage_i.fail || diff[32];
      p_d.acc  = diff[31:0];
    end else begin
      p_d.fail = stage_i.fail || (stage_i.acc != 32'd0);
    end
  end

  always_comb begin
    uid  = {1'b0, p_q.acc} + {1'b0, cfg_i.id_base};
    fail = p_q.fail;
    if (p_q.op == OP_BY_NAME) begin
      fail = p_q.fail || (uid > {1'b0, cfg_i.id_limit});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q      <= '0;
      done_q   <= 1'b0;
      status_q <= 1'b0;
      id_q     <= '0;
      name_q   <= '0;
    end else begin
      p_q    <= p_d;
      done_q <= p_q.vld;
      if (p_q.vld) begin
        status_q <= fail;
        if (fail) begin
          id_q   <= '0;
          name_q <= '0;
        end else begin
          id_q   <= (p_q.op == OP_BY_NAME) ? uid[31:0] : p_q.id;
          name_q <= p_q.text;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign id_out_o   = id_q;
  assign name_out_o = name_q;

endmodule

// ----- rtl/login_name_uid_translate.sv -----
// Login name / user id translator.
// Requests: pulse start with operation_i (0 by name, 1 by id) and the matching
// payload; busy is never raised, so a transaction can be issued every cycle.
// Each transaction returns exactly one result, shown for one cycle with
// done_o high: status_o (0 found, 1 not found), id_out_o and name_out_o
// (both zero when not found). The chain holds two front stages (range
// check, base offset), six character cells (one base-36 digit each), two
// back stages (base removal, id range check and output register).
// Throughput is one per cycle. The receiver has no way to stall; results
// must be captured when done_o is high. Reset clears the pipeline (nothing
// in flight is reported) and loads the register defaults. Registers over
// APB: name base at 0x0, id base at 0x4, id limit at 0x8; write them only
// while no transaction is in flight.
module login_name_uid_translate (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         operation_i,
  input  logic [55:0]                  name_bytes_i,
  input  logic [31:0]                  id_value_i,
  output logic                         done_o,
  output logic                         status_o,
  output logic [31:0]                  id_out_o,
  output logic [47:0]                  name_out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lnut_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import lnut_pkg::*;

  cfg_t   cfg_q;
  stage_t chain [NAME_CHARS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.name_base <= RST_NAME_BASE;
      cfg_q.id_base   <= RST_ID_BASE;
      cfg_q.id_limit  <= RST_ID_LIMIT;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_NAME_BASE: cfg_q.name_base <= pwdata;
        REG_ID_BASE:   cfg_q.id_base   <= pwdata;
        REG_ID_LIMIT:  cfg_q.id_limit  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_NAME_BASE: prdata = cfg_q.name_base;
      REG_ID_BASE:   prdata = cfg_q.id_base;
      REG_ID_LIMIT:  prdata = cfg_q.id_limit;
      default:       prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign busy   = 1'b0;

  lnut_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .operation_i  (operation_i),
    .name_bytes_i (name_bytes_i),
    .id_value_i   (id_value_i),
    .cfg_i        (cfg_q),
    .stage_o      (chain[0])
  );

  // decode takes characters first to last, encode produces them last to first
  for (genvar g = 0; g < NAME_CHARS; g++) begin : g_cell
    lnut_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .dec_letter_i (g < LETTER_CHARS),
      .stage_i      (chain[g]),
      .stage_o      (chain[g+1])
    );
  end

  lnut_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stage_i    (chain[NAME_CHARS]),
    .cfg_i      (cfg_q),
    .done_o     (done_o),
    .status_o   (status_o),
    .id_out_o   (id_out_o),
    .name_out_o (name_out_o)
  );

endmodule

// ----- rtl/lnut_chk.sv -----
module lnut_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        operation_i,
  input logic [55:0] name_bytes_i,
  input logic [31:0] id_value_i,
  input logic        done_o,
  input logic        status_o,
  input logic [31:0] id_out_o,
  input logic [47:0] name_out_o
);
  import lnut_pkg::*;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LATENCY done_o)
    else $error("accepted transaction produced no result");

  a_no_stray_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LATENCY))
    else $error("result without a matching transaction");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o |-> id_out_o == 32'd0 && name_out_o == 48'd0)
    else $error("not-found result carries data");

  a_id_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !status_o && $past(operation_i, LATENCY)
      |-> id_out_o == $past(id_value_i, LATENCY))
    else $error("by-id result does not echo the id");

  a_name_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !status_o && !$past(operation_i, LATENCY)
      |-> name_out_o == $past(name_bytes_i[55:8], LATENCY))
    else $error("by-name result does not echo the name");

endmodule

bind login_name_uid_translate lnut_chk u_lnut_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .operation_i  (operation_i),
  .name_bytes_i (name_bytes_i),
  .id_value_i   (id_value_i),
  .done_o       (done_o),
  .status_o     (status_o),
  .id_out_o     (id_out_o),
  .name_out_o   (name_out_o)
);

// ----- bench/login_name_uid_translate_tb.sv -----
`timescale 1ns / 1ps

module login_name_uid_translate_tb;
  import lnut_pkg::*;

  typedef struct packed {
    logic        status;
    logic [31:0] uid;
    logic [47:0] login;
  } lookup_result_t;

  class lookup_scoreboard;
    logic [31:0]    name_base;
    logic [31:0]    id_base;
    logic [31:0]    id_limit;
    lookup_result_t pending_q[$];
    int unsigned    errors;

    function new();
      name_base = RST_NAME_BASE;
      id_base   = RST_ID_BASE;
      id_limit  = RST_ID_LIMIT;
      errors    = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_NAME_BASE: name_base = value;
        REG_ID_BASE:   id_base   = value;
        REG_ID_LIMIT:  id_limit  = value;
        default: ;
      endcase
    endfunction

    function lookup_result_t translate(op_e op, logic [55:0] nm, logic [31:0] uid);
      lookup_result_t res;
      logic [63:0]    acc;
      logic [63:0]    digit;
      logic [7:0]     ch;
      logic [47:0]    text;
      bit             bad;
      int             k;
      res        = '0;
      res.status = 1'b1;
      acc        = '0;
      text       = '0;
      bad        = 1'b0;
      if (op == OP_BY_NAME) begin
        if (nm[7:0] != 8'h00) bad = 1'b1;
        for (k = 0; k < NAME_CHARS; k++) begin
          ch = nm[55 - 8*k -: 8];
          if (k < LETTER_CHARS) begin
            if (ch < ASCII_LA || ch > ASCII_LZ) bad = 1'b1;
            digit = 64'(ch) - 64'(LETTER_OFS);
          end else begin
            if (ch < ASCII_0 || ch > ASCII_9) bad = 1'b1;
            digit = 64'(ch) - 64'(ASCII_0);
          end
          acc = acc * 36 + digit;
        end
        // exact arithmetic: a name below the base is simply not found
        if (!bad && acc >= 64'(name_base)) begin
          acc = acc - 64'(name_base) + 64'(id_base);
          if (acc <= 64'(id_limit)) begin
            res.status = 1'b0;
            res.uid    = acc[31:0];
            res.login  = nm[55:8];
          end
        end
      end else if (uid >= id_base && uid <= id_limit) begin
        acc = 64'(uid) + 64'(name_base) - 64'(id_base);
        if (acc >= 64'd2176782336) bad = 1'b1;  // 36**6: needs a seventh digit
        for (k = NAME_CHARS - 1; k >= 0; k--) begin
          digit = acc % 36;
          acc   = acc / 36;
          if (k < LETTER_CHARS) begin
            if (digit < 10) bad = 1'b1;
            ch = LETTER_OFS + digit[7:0];
          end else begin
            if (digit >= 10) bad = 1'b1;
            ch = ASCII_0 + digit[7:0];
          end
          text[47 - 8*k -: 8] = ch;
        end
        if (!bad) begin
          res.status = 1'b0;
          res.uid    = uid;
          res.login  = text;
        end
      end
      return res;
    endfunction

    function void note_request(op_e op, logic [55:0] nm, logic [31:0] uid);
      pending_q.push_back(translate(op, nm, uid));
    endfunction

    task check_result(logic status, logic [31:0] uid, logic [47:0] login);
      lookup_result_t exp_r;
      if (pending_q.size() == 0) begin
        report("result with no transaction outstanding");
        return;
      end
      exp_r = pending_q.pop_front();
      if (status !== exp_r.status)
        report($sformatf("status %0b, expected %0b", status, exp_r.status));
      if (uid !== exp_r.uid)
        report($sformatf("id_out %0d, expected %0d", uid, exp_r.uid));
      if (login !== exp_r.login)
        report($sformatf("name_out %h, expected %h", login, exp_r.login));
    endtask
  endclass

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              start        = 1'b0;
  logic              busy;
  logic              operation_i  = 1'b0;
  logic [55:0]       name_bytes_i = '0;
  logic [31:0]       id_value_i   = '0;
  logic              done_o;
  logic              status_o;
  logic [31:0]       id_out_o;
  logic [47:0]       name_out_o;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [ADDR_W-1:0] paddr        = '0;
  logic [31:0]       pwdata       = '0;
  logic [31:0]       prdata;
  logic              pready;

  logic [31:0] cur_nb = RST_NAME_BASE;
  logic [31:0] cur_ib = RST_ID_BASE;

  lookup_scoreboard sb = new();

  login_name_uid_translate dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .name_bytes_i (name_bytes_i),
    .id_value_i   (id_value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .id_out_o     (id_out_o),
    .name_out_o   (name_out_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // results first: a transaction accepted on this edge is always younger
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(status_o, id_out_o, name_out_o);
      if (start && !busy) sb.note_request(op_e'(operation_i), name_bytes_i, id_value_i);
    end
  end

  task automatic issue(op_e op, logic [55:0] nm, logic [31:0] uid);
    start        <= 1'b1;
    operation_i  <= op;
    name_bytes_i <= nm;
    id_value_i   <= uid;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic quiesce();
    int unsigned waited;
    waited = 0;
    start <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (sb.pending_q.size() != 0 && waited < 2000);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    // read back through a second transfer
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value)
      sb.report($sformatf("reg %0d reads %h, wrote %h", idx, prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_regs(logic [31:0] nb, logic [31:0] ib, logic [31:0] il);
    repeat (LATENCY) @(posedge clk_i);
    write_reg(REG_NAME_BASE, nb);
    write_reg(REG_ID_BASE, ib);
    write_reg(REG_ID_LIMIT, il);
    cur_nb = nb;
    cur_ib = ib;
  endtask

  initial begin
    logic [55:0] nm;
    logic [63:0] val;
    logic [31:0] uid;
    logic [31:0] nb;
    logic [31:0] ib;
    logic [31:0] il;
    logic [7:0]  d;
    op_e         op;
    bit          burst;
    int          p;
    int          i;
    int          k;
    int unsigned r;
    burst = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values: both ends of the name space map onto the id range
    issue(OP_BY_NAME, {"aaa000", 8'h00}, 32'hFFFF_FFFF);
    issue(OP_BY_NAME, {"zzz999", 8'h00}, 32'h0);
    issue(OP_BY_NAME, {"aaa000", 8'h01}, 32'd100000);
    issue(OP_BY_NAME, {8'h60, "aa000", 8'h00}, 32'h0);
    issue(OP_BY_NAME, {"aa", 8'h7B, "000", 8'h00}, 32'h0);
    issue(OP_BY_NAME, {"abc/00", 8'h00}, 32'h0);
    issue(OP_BY_NAME, {"abc00:", 8'h00}, 32'h0);
    issue(OP_BY_ID, 56'hFF_FFFF_FFFF_FFFF, 32'd100000);
    issue(OP_BY_ID, 56'h0, 32'd1554923197);
    issue(OP_BY_ID, 56'h0, 32'd99999);
    issue(OP_BY_ID, 56'h0, 32'd1554923198);
    issue(OP_BY_ID, 56'h0, 32'd100010);   // last character would be a letter
    issue(OP_BY_ID, 56'h0, 32'h0);
    issue(OP_BY_ID, 56'h0, 32'hFFFF_FFFF);
    quiesce();

    program_regs(32'h0, 32'h0, 32'hFFFF_FFFF);
    issue(OP_BY_ID, 56'h0, 32'd5);              // too few digits
    issue(OP_BY_ID, 56'h0, 32'd2176782336);     // seven digits
    issue(OP_BY_NAME, {"mno456", 8'h00}, 32'h0);
    quiesce();

    program_regs(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    issue(OP_BY_NAME, {"zzz999", 8'h00}, 32'h0); // name below the base
    issue(OP_BY_ID, 56'h0, 32'h0);
    quiesce();

    program_regs(RST_NAME_BASE, RST_ID_LIMIT, RST_ID_BASE);  // empty id range
    issue(OP_BY_NAME, {"aaa000", 8'h00}, 32'h0);
    issue(OP_BY_ID, 56'h0, 32'd100000);
    quiesce();

    for (p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin
          nb = RST_NAME_BASE;
          ib = RST_ID_BASE;
          il = RST_ID_LIMIT;
        end
        1: begin
          nb = $urandom_range(0, 1243848960);
          ib = $urandom_range(0, 32'h7FFF_FFFF);
          il = ib + $urandom_range(1000, 32'h7FFF_FFFF);
        end
        2: begin
          nb = $urandom();
          ib = $urandom();
          il = $urandom();
        end
        default: begin
          // a large id base pushes the exact sum past 32 bits
          nb = 32'h0;
          ib = ($urandom_range(0, 1) != 0) ? 32'hFFFF_0000 : 32'h0;
          il = 32'hFFFF_FFFF;
        end
      endcase
      program_regs(nb, ib, il);

      for (i = 0; i < 192; i++) begin
        if (i % 48 == 0) burst = ($urandom_range(0, 3) == 0);
        val = '0;
        for (k = 0; k < NAME_CHARS; k++) begin
          if (k < LETTER_CHARS) begin
            d = 8'($urandom_range(10, 35));
            nm[55 - 8*k -: 8] = LETTER_OFS + d;
          end else begin
            d = 8'($urandom_range(0, 9));
            nm[55 - 8*k -: 8] = ASCII_0 + d;
          end
          val = val * 36 + 64'(d);
        end
        nm[7:0] = 8'h00;
        uid = val[31:0] - cur_nb + cur_ib;
        op  = op_e'($urandom_range(0, 1));
        r   = $urandom_range(0, 99);
        if (r < 8) begin
          uid = uid + $urandom_range(0, 2) - 1;
        end else if (r < 25) begin
          k = $urandom_range(0, NAME_CHARS);
          if (k == NAME_CHARS) nm[7:0] = 8'($urandom_range(1, 255));
          else nm[55 - 8*k -: 8] = 8'($urandom_range(0, 255));
          uid = $urandom();
        end else if (r < 35) begin
          nm  = 56'({$urandom(), $urandom()});
          uid = $urandom();
        end
        // the field the operation does not use carries noise
        if (op == OP_BY_NAME) uid = $urandom();
        else nm = 56'({$urandom(), $urandom()});
        issue(op, nm, uid);

        r = $urandom_range(0, 99);
        if ($urandom_range(0, 149) == 0) begin
          quiesce();
        end else if (!burst && r >= 55) begin
          start <= 1'b0;
          if (r < 92) repeat ($urandom_range(1, 3)) @(posedge clk_i);
          else repeat ($urandom_range(8, 40)) @(posedge clk_i);
        end
      end
      quiesce();
    end

    repeat (LATENCY + 5) @(posedge clk_i);
    if (sb.pending_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));
    if (sb.errors == 0) begin
      $display("login_name_uid_translate test passed");
    end else begin
      $display("login_name_uid_translate test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("login_name_uid_translate test failed");
    $finish;
  end

endmodule

// ----- login_name_uid_translate.f -----
rtl/lnut_pkg.sv
rtl/lnut_front.sv
rtl/lnut_cell.sv
rtl/lnut_back.sv
rtl/login_name_uid_translate.sv
rtl/lnut_chk.sv
bench/login_name_uid_translate_tb.sv
